// ===== hw/rtl/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern search block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package mbps_pkg;

	// Default pattern capacity in bytes.
	localparam int MAX_PATTERN_DEF = 256;

	// Widths of the channel fields.
	localparam int OPCODE_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int POSITION_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int LENGTH_W   = 9;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_FIRST  = 1'b1;

	// Register reset values.
	localparam logic [LENGTH_W-1:0] PATTERN_LENGTH_RST = 9'd1;
	localparam logic                STOP_AT_FIRST_RST  = 1'b1;

	// Item opcodes.
	localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SCAN    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic restart;
		logic capture;
	} mbps_cmd_t;

endpackage

// ===== hw/rtl/mbps_in_if.sv =====
// Input channel of the masked byte pattern search block: valid, ready and one item.
// Depends on mbps_pkg.
interface mbps_in_if;
	logic                               valid;
	logic                               ready;
	logic [mbps_pkg::OPCODE_W-1:0]      opcode;
	logic [mbps_pkg::BYTE_W-1:0]        entry_index;
	logic [mbps_pkg::BYTE_W-1:0]        pattern_byte;
	logic [mbps_pkg::BYTE_W-1:0]        mask_byte;
	logic [mbps_pkg::BYTE_W-1:0]        data_byte;

	modport source (
		output valid, opcode, entry_index, pattern_byte, mask_byte, data_byte,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, pattern_byte, mask_byte, data_byte,
		output ready
	);
endinterface

// ===== hw/rtl/mbps_out_if.sv =====
// Result channel of the masked byte pattern search block: valid, ready and one result.
// Depends on mbps_pkg.
interface mbps_out_if;
	logic                                valid;
	logic                                ready;
	logic                                match_found;
	logic [mbps_pkg::POSITION_W-1:0]     match_start;

	modport source (
		output valid, match_found, match_start,
		input  ready
	);
	modport sink (
		input  valid, match_found, match_start,
		output ready
	);
endinterface

// ===== hw/rtl/mbps_ctrl.sv =====
// Controller of the masked byte pattern search block: handshakes and item decode.
// Tracks whether the result register is occupied and issues datapath commands.
// Depends on mbps_pkg.
module mbps_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [mbps_pkg::OPCODE_W-1:0] opcode,
	output logic                          in_ready,
	input  logic                          out_ready,
	output logic                          out_valid,
	output mbps_pkg::mbps_cmd_t           cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A new item may enter whenever the result register is free or being drained.
	assign out_valid = (state_q == ST_FULL);
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;

	// Next state of the result register occupancy.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (accept) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				if (accept) begin
					state_d = ST_FULL;
				end else if (out_ready) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode the accepted item into datapath commands.
	always_comb begin
		cmd.load    = accept && (opcode == mbps_pkg::OP_LOAD);
		cmd.scan    = accept && (opcode == mbps_pkg::OP_SCAN);
		cmd.restart = accept && (opcode == mbps_pkg::OP_RESTART);
		cmd.capture = accept;
	end

endmodule

// ===== hw/rtl/mbps_datapath.sv =====
// Datapath of the masked byte pattern search block: a row of comparing cells,
// one per pattern position, the stream position counter and the result register.
// Depends on mbps_pkg.
module mbps_datapath #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mbps_pkg::mbps_cmd_t               cmd,
	input  logic [mbps_pkg::BYTE_W-1:0]       entry_index,
	input  logic [mbps_pkg::BYTE_W-1:0]       pattern_byte,
	input  logic [mbps_pkg::BYTE_W-1:0]       mask_byte,
	input  logic [mbps_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              match_found,
	output logic [mbps_pkg::POSITION_W-1:0]   match_start
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	// Compare width that holds both the length register and MAX_PATTERN itself.
	localparam int CW    = (IDX_W + 1 > mbps_pkg::LENGTH_W) ? IDX_W + 1 : mbps_pkg::LENGTH_W;

	logic [mbps_pkg::BYTE_W-1:0]     pat_q [MAX_PATTERN];
	logic [mbps_pkg::BYTE_W-1:0]     msk_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]          pm_q;
	logic [MAX_PATTERN-1:0]          pm_d;
	logic [MAX_PATTERN-1:0]          fits;
	logic [mbps_pkg::POSITION_W-1:0] pos_q;
	logic                            seen_q;
	logic [mbps_pkg::LENGTH_W-1:0]   len_q;
	logic                            stop_q;
	logic [CW-1:0]                   len_raw;
	logic [CW-1:0]                   len_eff;
	logic [IDX_W-1:0]                sel;
	logic                            hit;
	logic                            found;
	logic [mbps_pkg::POSITION_W-1:0] start;
	logic                            found_q;
	logic [mbps_pkg::POSITION_W-1:0] start_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= mbps_pkg::PATTERN_LENGTH_RST;
			stop_q <= mbps_pkg::STOP_AT_FIRST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbps_pkg::REG_PATTERN_LENGTH: len_q  <= cfg_data[mbps_pkg::LENGTH_W-1:0];
				mbps_pkg::REG_STOP_AT_FIRST:  stop_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// One cell per pattern position: it stores its entry and compares the scanned byte.
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.load && (CW'(entry_index) == CW'(i))) begin
				pat_q[i] <= pattern_byte;
				msk_q[i] <= mask_byte;
			end
		end

		assign fits[i] = ((data_byte ^ pat_q[i]) & ~msk_q[i]) == '0;

		if (i == 0) begin : g_head
			assign pm_d[i] = fits[i];
		end else begin : g_link
			assign pm_d[i] = pm_q[i-1] && fits[i];
		end
	end

	// The partial-match chain advances on each scanned byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= '0;
		end else if (cmd.restart) begin
			pm_q <= '0;
		end else if (cmd.scan) begin
			pm_q <= pm_d;
		end
	end

	// Clamp the pattern length into 1..MAX_PATTERN and pick the last active cell.
	always_comb begin
		len_raw = CW'(len_q);
		if (len_raw == '0) begin
			len_eff = CW'(1);
		end else if (len_raw > CW'(MAX_PATTERN)) begin
			len_eff = CW'(MAX_PATTERN);
		end else begin
			len_eff = len_raw;
		end
		sel = IDX_W'(len_eff - CW'(1));
	end

	assign hit   = pm_d[sel];
	assign found = cmd.scan && hit && !(stop_q && seen_q);
	assign start = pos_q - mbps_pkg::POSITION_W'(sel);

	// Stream position and the first-match flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= 1'b0;
		end else if (cmd.restart) begin
			pos_q  <= '0;
			seen_q <= 1'b0;
		end else if (cmd.scan) begin
			pos_q <= pos_q + mbps_pkg::POSITION_W'(1);
			if (found) begin
				seen_q <= 1'b1;
			end
		end
	end

	// Result register, loaded for every accepted item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			found_q <= found;
			start_q <= found ? start : '0;
		end
	end

	assign match_found = found_q;
	assign match_start = start_q;

endmodule

// ===== hw/rtl/masked_byte_pattern_search.sv =====
// Top level of the masked byte pattern search block.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if, mbps_ctrl and mbps_datapath.
//
// Usage:
// Items arrive on in_ch: a load writes one pattern and mask entry, a scan
// presents one stream byte, a restart clears the partial-match chain, the
// stream position and the first-match flag. Every item gives exactly one
// result transaction on out_ch; only a scan can report a match, with the
// stream position of the match's first byte.
// The result of an accepted item is registered and valid in the next
// cycle. Throughput is one item per cycle while out_ch takes every result;
// the whole row of comparing cells, one per pattern position, evaluates a
// scanned byte combinationally, followed by the result register. When
// out_ch stalls, the result register holds its transaction and in_ch
// drops ready until the result is taken. The configuration port writes
// pattern_length and stop_at_first with cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, which it does
// not enforce. Reset clears the chain, the position, the flag and the
// registers to their defaults; pattern entries stay undefined until loaded.
module masked_byte_pattern_search #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mbps_in_if.sink                         in_ch,
	mbps_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

	mbps_pkg::mbps_cmd_t cmd;
	logic                in_ready;
	logic                out_valid;

	// Handshake control and item decode.
	mbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.opcode    (in_ch.opcode),
		.in_ready  (in_ready),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Cell row, counters and result register.
	mbps_datapath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.entry_index  (in_ch.entry_index),
		.pattern_byte (in_ch.pattern_byte),
		.mask_byte    (in_ch.mask_byte),
		.data_byte    (in_ch.data_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.match_found  (out_ch.match_found),
		.match_start  (out_ch.match_start)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

endmodule

// ===== hw/rtl/mbps_checker.sv =====
// Port-level checks of the masked byte pattern search block, bound to its top level.
// Depends on mbps_pkg and masked_byte_pattern_search.
module mbps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [mbps_pkg::OPCODE_W-1:0] in_opcode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_match_found
);

	// A pending result transaction stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result blocks the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while the result register was stalled");

	// Every accepted item gives a result in the following cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after an accepted item");

	// Only a scan item can report a match.
	a_match_only_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode != mbps_pkg::OP_SCAN)
		|=> !out_match_found)
		else $error("match reported for an item that is not a scan");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.in_opcode       (in_ch.opcode),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_match_found (out_ch.match_found)
);

// ===== dv/tb_masked_byte_pattern_search.sv =====
// Self-checking testbench for masked_byte_pattern_search: directed and random item streams.
// Predicts every result transaction from its own copy of the pattern table and match chain.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if and the masked_byte_pattern_search RTL.
module tb_masked_byte_pattern_search;

	localparam int MAXP = mbps_pkg::MAX_PATTERN_DEF;
	localparam logic [mbps_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS = 750;
	localparam int MAX_GAP = 19;
	localparam int SETTLE_CYCLES = 4;
	localparam int LENGTH_CODE_MAX = (1 << mbps_pkg::LENGTH_W) - 1;

	typedef struct packed {
		logic [mbps_pkg::OPCODE_W-1:0] opcode;
		logic [mbps_pkg::BYTE_W-1:0]   entry_index;
		logic [mbps_pkg::BYTE_W-1:0]   pattern_byte;
		logic [mbps_pkg::BYTE_W-1:0]   mask_byte;
		logic [mbps_pkg::BYTE_W-1:0]   data_byte;
	} search_item_t;

	typedef struct packed {
		logic                            match_found;
		logic [mbps_pkg::POSITION_W-1:0] match_start;
	} search_result_t;

	localparam int ITEM_W = $bits(search_item_t);

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;

	mbps_in_if  in_ch ();
	mbps_out_if out_ch ();

	masked_byte_pattern_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's state and registers.
	logic [mbps_pkg::BYTE_W-1:0]     pattern_mem [MAXP];
	logic [mbps_pkg::BYTE_W-1:0]     mask_mem [MAXP];
	logic [MAXP-1:0]                 partial_chain;
	logic [mbps_pkg::POSITION_W-1:0] scan_position;
	logic                            match_reported;
	logic [mbps_pkg::LENGTH_W-1:0]   length_reg;
	logic                            stop_reg;

	search_result_t expected_results [$];
	int mismatch_count = 0;
	int scored_items = 0;
	bit steady_source = 1'b0;
	bit steady_sink = 1'b0;
	bit result_taken = 1'b0;
	int stall_left = 0;

	always #5 clk = ~clk;

	// A stream byte fits a pattern position when every cared-for bit agrees.
	function automatic bit byte_fits(int pos, logic [mbps_pkg::BYTE_W-1:0] b);
		return ((b ^ pattern_mem[pos]) & ~mask_mem[pos]) == '0;
	endfunction

	// Works out the result of one accepted item and advances the shadow state.
	function automatic search_result_t predict_search_result(search_item_t it);
		search_result_t r;
		logic [MAXP-1:0] next_chain;
		int eff_len;
		int i;
		r = '0;
		case (it.opcode)
			mbps_pkg::OP_LOAD: begin
				pattern_mem[it.entry_index] = it.pattern_byte;
				mask_mem[it.entry_index] = it.mask_byte;
			end
			mbps_pkg::OP_SCAN: begin
				eff_len = (length_reg == 0) ? 1 : (length_reg > MAXP) ? MAXP : int'(length_reg);
				for (i = MAXP - 1; i > 0; i--)
					next_chain[i] = partial_chain[i-1] && byte_fits(i, it.data_byte);
				next_chain[0] = byte_fits(0, it.data_byte);
				partial_chain = next_chain;
				if (partial_chain[eff_len-1] && !(stop_reg && match_reported)) begin
					r.match_found = 1'b1;
					r.match_start = scan_position - mbps_pkg::POSITION_W'(eff_len - 1);
					match_reported = 1'b1;
				end
				scan_position = scan_position + mbps_pkg::POSITION_W'(1);
			end
			mbps_pkg::OP_RESTART: begin
				partial_chain = '0;
				scan_position = '0;
				match_reported = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Result checker: every accepted result transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		search_result_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			result_taken = 1'b1;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, match_start", out_ch.match_start, '0);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.match_found !== want.match_found)
					report_mismatch("match_found", 32'(out_ch.match_found),
						32'(want.match_found));
				if (out_ch.match_start !== want.match_start)
					report_mismatch("match_start", out_ch.match_start, want.match_start);
			end
		end
	end

	// Result sink: draws a stall for every result once the previous one is taken.
	always @(negedge clk) begin
		if (result_taken) begin
			stall_left = steady_sink ? 0 : $urandom_range(0, MAX_GAP);
			result_taken = 1'b0;
		end
		if (stall_left > 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Sends one item; entered and left just after a falling edge.
	task automatic send_item(search_item_t it);
		int gap;
		gap = steady_source ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = it.opcode;
		in_ch.entry_index = it.entry_index;
		in_ch.pattern_byte = it.pattern_byte;
		in_ch.mask_byte = it.mask_byte;
		in_ch.data_byte = it.data_byte;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		expected_results.push_back(predict_search_result(it));
		if (it.opcode != OP_UNUSED)
			scored_items++;
		@(negedge clk);
	endtask

	// Item with random content in the fields that its opcode does not use.
	function automatic search_item_t random_item(logic [mbps_pkg::OPCODE_W-1:0] op);
		search_item_t it;
		it = ITEM_W'({$urandom, $urandom});
		it.opcode = op;
		return it;
	endfunction

	task automatic load_entry(logic [mbps_pkg::BYTE_W-1:0] idx,
			logic [mbps_pkg::BYTE_W-1:0] pat, logic [mbps_pkg::BYTE_W-1:0] msk);
		search_item_t it;
		it = random_item(mbps_pkg::OP_LOAD);
		it.entry_index = idx;
		it.pattern_byte = pat;
		it.mask_byte = msk;
		send_item(it);
	endtask

	task automatic scan_byte(logic [mbps_pkg::BYTE_W-1:0] b);
		search_item_t it;
		it = random_item(mbps_pkg::OP_SCAN);
		it.data_byte = b;
		send_item(it);
	endtask

	// Lets every outstanding result drain so that the block is idle.
	task automatic wait_idle();
		in_ch.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_register(logic [mbps_pkg::CFG_IDX_W-1:0] idx,
			logic [mbps_pkg::CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == mbps_pkg::REG_PATTERN_LENGTH)
			length_reg = value[mbps_pkg::LENGTH_W-1:0];
		else
			stop_reg = value[0];
	endtask

	// Writes a length, sometimes as the out-of-range code that acts as the same length.
	task automatic set_length(int len);
		int code;
		code = len;
		if (len == 1 && $urandom_range(0, 1) == 0)
			code = 0;
		else if (len == MAXP && $urandom_range(0, 1) == 0)
			code = $urandom_range(MAXP + 1, LENGTH_CODE_MAX);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, mbps_pkg::CFG_DATA_W'(code));
	endtask

	task automatic choose_pacing();
		steady_source = ($urandom_range(0, 3) == 0);
		steady_sink = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [mbps_pkg::BYTE_W-1:0] random_mask();
		case ($urandom_range(0, 7))
			0, 1, 2: return '0;
			3: return '1;
			4, 5: return mbps_pkg::BYTE_W'($urandom & $urandom);
			default: return mbps_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	// A byte that fits the given position, with random don't-care bits.
	function automatic logic [mbps_pkg::BYTE_W-1:0] fitting_byte(int pos);
		logic [mbps_pkg::BYTE_W-1:0] noise;
		noise = mbps_pkg::BYTE_W'($urandom);
		return (pattern_mem[pos] & ~mask_mem[pos]) | (noise & mask_mem[pos]);
	endfunction

	// A byte that fails the given position, unless every bit there is ignored.
	function automatic logic [mbps_pkg::BYTE_W-1:0] misfit_byte(int pos);
		logic [mbps_pkg::BYTE_W-1:0] b;
		int bit_no;
		b = fitting_byte(pos);
		if (mask_mem[pos] != '1) begin
			do bit_no = $urandom_range(0, mbps_pkg::BYTE_W - 1); while (mask_mem[pos][bit_no]);
			b[bit_no] = ~b[bit_no];
		end
		return b;
	endfunction

	task automatic scan_fitting_run(int count);
		int k;
		for (k = 0; k < count; k++)
			scan_byte(fitting_byte(k));
	endtask

	// Every pattern entry is written once, so no comparing cell ever sees an unwritten entry.
	task automatic test_fill_pattern_table();
		int k;
		choose_pacing();
		for (k = 0; k < MAXP; k++)
			load_entry(mbps_pkg::BYTE_W'(k), mbps_pkg::BYTE_W'($urandom), random_mask());
	endtask

	// One-byte pattern under the reset registers: first match only, restart, full masks.
	task automatic test_single_byte_match();
		choose_pacing();
		load_entry(8'd0, 8'hff, 8'h00);
		scan_byte(8'hff);
		scan_byte(8'hff);
		scan_byte(8'h00);
		send_item(random_item(mbps_pkg::OP_RESTART));
		scan_byte(8'h00);
		scan_byte(8'hff);
		send_item(random_item(OP_UNUSED));
		// Upper data bits set to check that only bit 0 reaches the stop flag.
		write_register(mbps_pkg::REG_STOP_AT_FIRST, 9'h1fe);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, 9'd0);
		scan_byte(8'hff);
		scan_byte(8'hff);
		load_entry(8'd0, 8'h00, 8'hff);
		scan_byte(8'h5a);
		load_entry(8'd0, 8'h00, 8'h00);
		scan_byte(8'hff);
		scan_byte(8'h00);
	endtask

	// Short pattern with overlaps, a length change mid-stream and the length limits.
	task automatic test_length_extremes();
		choose_pacing();
		load_entry(8'd0, 8'ha5, 8'h00);
		load_entry(8'd1, 8'h3c, 8'h0f);
		load_entry(8'd2, 8'h00, 8'hff);
		load_entry(8'd255, 8'hff, 8'h00);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, 9'd3);
		send_item(random_item(mbps_pkg::OP_RESTART));
		scan_byte(8'ha5);
		scan_byte(8'h30);
		scan_byte(8'hff);
		scan_byte(8'ha5);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, 9'd2);
		scan_byte(8'h3f);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, 9'h1ff);
		scan_byte(8'ha5);
		write_register(mbps_pkg::REG_PATTERN_LENGTH, 9'd256);
		scan_byte(8'h00);
		write_register(mbps_pkg::REG_STOP_AT_FIRST, 9'h001);
	endtask

	// Random scenarios: a fresh pattern, registers, then mostly embedded patterns among noise.
	task automatic test_random_search();
		int len;
		int reps;
		int k;
		int choice;
		bit long_pending;
		bit repeated;
		logic [mbps_pkg::BYTE_W-1:0] fill;
		long_pending = 1'b1;
		while (scored_items < TOTAL_ITEMS) begin
			choose_pacing();
			if (long_pending)
				len = MAXP;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(1, 8);
			// The longest pattern keeps the table contents; short ones are reloaded.
			if (!long_pending) begin
				fill = mbps_pkg::BYTE_W'($urandom);
				repeated = ($urandom_range(0, 4) == 0);
				for (k = 0; k < len; k++)
					load_entry(mbps_pkg::BYTE_W'(k),
						repeated ? fill : mbps_pkg::BYTE_W'($urandom), random_mask());
			end
			set_length(len);
			write_register(mbps_pkg::REG_STOP_AT_FIRST, mbps_pkg::CFG_DATA_W'($urandom));
			if ($urandom_range(0, 3) != 0)
				send_item(random_item(mbps_pkg::OP_RESTART));
			if (long_pending) begin
				scan_fitting_run(MAXP);
				scan_byte(mbps_pkg::BYTE_W'($urandom));
				long_pending = 1'b0;
			end else begin
				reps = $urandom_range(3, 12);
				repeat (reps) begin
					choice = $urandom_range(0, 99);
					if (choice < 55) begin
						scan_fitting_run(len);
					end else if (choice < 70) begin
						k = $urandom_range(0, len - 1);
						scan_fitting_run(k);
						scan_byte(misfit_byte(k));
					end else if (choice < 82) begin
						scan_byte(mbps_pkg::BYTE_W'($urandom));
					end else if (choice < 87) begin
						send_item(random_item(mbps_pkg::OP_RESTART));
					end else if (choice < 91) begin
						send_item(random_item(OP_UNUSED));
					end else if (choice < 95) begin
						// Loads beyond the active length only touch unused cells.
						if (len < MAXP)
							load_entry(mbps_pkg::BYTE_W'($urandom_range(len, MAXP - 1)),
								mbps_pkg::BYTE_W'($urandom), random_mask());
					end else begin
						len = $urandom_range(1, len);
						set_length(len);
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = mbps_pkg::OP_LOAD;
		in_ch.entry_index = '0;
		in_ch.pattern_byte = '0;
		in_ch.mask_byte = '0;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		foreach (pattern_mem[k]) begin
			pattern_mem[k] = '0;
			mask_mem[k] = '0;
		end
		partial_chain = '0;
		scan_position = '0;
		match_reported = 1'b0;
		length_reg = mbps_pkg::PATTERN_LENGTH_RST;
		stop_reg = mbps_pkg::STOP_AT_FIRST_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_pattern_table();
		test_single_byte_match();
		test_length_extremes();
		test_random_search();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_in_if.sv
hw/rtl/mbps_out_if.sv
hw/rtl/mbps_ctrl.sv
hw/rtl/mbps_datapath.sv
hw/rtl/masked_byte_pattern_search.sv
hw/rtl/mbps_checker.sv
dv/tb_masked_byte_pattern_search.sv
